FILE: rtl/kpd_pkg.sv
// Shared types and codes for the key press duration classifier.
`default_nettype none
package kpd_pkg;

  localparam int CNT_W = 11;
  localparam int CFG_W = 11;
  localparam int CFG_AW = 2;

  localparam logic [CFG_AW-1:0] CFG_LONG = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_ENTER_MID = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_ESC_VLONG = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_HOLD_LIMIT = 2'd3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [1:0] PH_HOLD = 2'd2;
  localparam logic [1:0] PH_WAIT = 2'd3;

  localparam logic [1:0] K_ESC = 2'd0;
  localparam logic [1:0] K_ENTER = 2'd1;
  localparam logic [1:0] K_UP = 2'd2;
  localparam logic [1:0] K_DOWN = 2'd3;

  localparam logic [3:0] EV_NONE = 4'd0;
  localparam logic [3:0] EV_ENTER_SHORT = 4'd1;
  localparam logic [3:0] EV_ENTER_3S = 4'd2;
  localparam logic [3:0] EV_ENTER_6S = 4'd3;
  localparam logic [3:0] EV_ENTER_15S = 4'd4;
  localparam logic [3:0] EV_ESC_SHORT = 4'd5;
  localparam logic [3:0] EV_ESC_3S = 4'd6;
  localparam logic [3:0] EV_ESC_9S = 4'd7;
  localparam logic [3:0] EV_UP = 4'd8;
  localparam logic [3:0] EV_DOWN = 4'd9;

  localparam logic [1:0] STG_NONE = 2'd0;
  localparam logic [1:0] STG_3S = 2'd1;
  localparam logic [1:0] STG_6S = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] long_ticks;
    logic [CFG_W-1:0] enter_mid_ticks;
    logic [CFG_W-1:0] esc_very_long_ticks;
    logic [CFG_W-1:0] hold_limit_ticks;
  } cfg_t;

  // packed so that bit 0 is esc_level, bit 4 is sleep_block
  typedef struct packed {
    logic sleep_block;
    logic down_level;
    logic up_level;
    logic enter_level;
    logic esc_level;
  } tick_t;

  typedef struct packed {
    logic [1:0] enter_stage;
    logic beep;
    logic [3:0] key_event;
  } res_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [1:0] held_key;
    logic [CNT_W-1:0] hold_count;
    logic [1:0] marks;
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/key_press_duration_classifier.sv
// Top level: stream ports, input and result registers, classifier state.
`default_nettype none
// Debounced key classifier. Each input request is one 10 ms scan tick carrying four
// active-low key levels and a sleep flag; each tick yields exactly one result
// request (key event, beep pulse, enter stage notice). One tick is accepted per
// clock while in_tready is high; out_tvalid for a tick rises after the input register,
// a single pass of step logic and the result register. While a result waits for the
// consumer the input register takes at most one more tick and then in_tready drops
// until the result is taken. The user must write the thresholds through
// cfg_we/cfg_addr/cfg_wdata only while the block is idle; the block does not enforce it.
module key_press_duration_classifier
  import kpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // esc_level, enter_level, up_level, down_level, sleep_block, 3 zero bits
  input  wire logic [7:0]        in_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // key_event[3:0], beep, enter_stage[1:0], 1 zero bit
  output logic [7:0]             out_tdata,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  cfg_t cfg;
  tick_t tick_r;
  logic in_vld_r;
  logic in_vld_nxt;
  state_t st_r;
  state_t st_nxt;
  res_t res;
  res_t res_r;
  logic out_vld_r;
  logic out_vld_nxt;
  logic in_acc;
  logic fire;

  kpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kpd_step u_step (
    .tick   (tick_r),
    .st     (st_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign fire = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) in_vld_nxt = 1'b1;
    else if (fire) in_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r;
    if (fire) out_vld_nxt = 1'b1;
    else if (out_tready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      st_r <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (fire) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) tick_r <= tick_t'(in_tdata[4:0]);
    if (fire) res_r <= res;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = {1'b0, res_r};

`ifndef ASSERT_OFF
  a_beep_stage_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(res_r.beep && res_r.enter_stage != STG_NONE))
    else $error("beep and enter stage notice in the same result");

  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> res_r.key_event <= EV_DOWN)
    else $error("key event code out of range");

  a_debounce_once: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !tick_r.sleep_block && st_r.phase == PH_DEBOUNCE) |=>
      st_r.phase != PH_DEBOUNCE)
    else $error("debounce lasted more than one tick");
`endif

endmodule
`default_nettype wire

FILE: rtl/kpd_cfg_regs.sv
// Threshold register file written through the plain configuration port.
`default_nettype none
module kpd_cfg_regs
  import kpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  output cfg_t                   cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_LONG:       cfg_nxt.long_ticks = cfg_wdata;
        CFG_ENTER_MID:  cfg_nxt.enter_mid_ticks = cfg_wdata;
        CFG_ESC_VLONG:  cfg_nxt.esc_very_long_ticks = cfg_wdata;
        CFG_HOLD_LIMIT: cfg_nxt.hold_limit_ticks = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_ticks <= CFG_W'(300);
      cfg_r.enter_mid_ticks <= CFG_W'(600);
      cfg_r.esc_very_long_ticks <= CFG_W'(900);
      cfg_r.hold_limit_ticks <= CFG_W'(1500);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: rtl/kpd_step.sv
// Per-tick next-state and result logic of the key classifier.
`default_nettype none
module kpd_step
  import kpd_pkg::*;
(
  input  tick_t  tick,
  input  state_t st,
  input  cfg_t   cfg,
  output state_t st_nxt,
  output res_t   res
);

  function automatic logic [3:0] classify(input logic [1:0] key, input logic [CNT_W:0] i,
                                          input cfg_t c);
    logic [3:0] ev;
    begin
      case (key)
        K_ESC: begin
          if (i > {1'b0, c.esc_very_long_ticks}) ev = EV_ESC_9S;
          else if (i > {1'b0, c.long_ticks}) ev = EV_ESC_3S;
          else ev = EV_ESC_SHORT;
        end
        K_ENTER: begin
          if (i > {1'b0, c.hold_limit_ticks}) ev = EV_ENTER_15S;
          else if (i > {1'b0, c.enter_mid_ticks}) ev = EV_ENTER_6S;
          else if (i > {1'b0, c.long_ticks}) ev = EV_ENTER_3S;
          else ev = EV_ENTER_SHORT;
        end
        K_UP:    ev = EV_UP;
        default: ev = EV_DOWN;
      endcase
      return ev;
    end
  endfunction

  logic [3:0] dn;
  logic any_dn;
  logic [1:0] pick;
  logic [CNT_W:0] cnt_inc;
  logic [CNT_W:0] lim_ext;

  assign dn = ~{tick.down_level, tick.up_level, tick.enter_level, tick.esc_level};
  assign any_dn = |dn;
  assign pick = dn[K_ESC] ? K_ESC : dn[K_ENTER] ? K_ENTER : dn[K_UP] ? K_UP : K_DOWN;
  assign cnt_inc = {1'b0, st.hold_count} + {{CNT_W{1'b0}}, 1'b1};
  assign lim_ext = {1'b0, cfg.hold_limit_ticks};

  always_comb begin
    st_nxt = st;
    res.key_event = EV_NONE;
    res.beep = 1'b0;
    res.enter_stage = STG_NONE;
    if (!tick.sleep_block) begin
      case (st.phase)
        PH_IDLE: begin
          if (any_dn) st_nxt.phase = PH_DEBOUNCE;
        end
        PH_DEBOUNCE: begin
          if (!any_dn) begin
            st_nxt.phase = PH_IDLE;
          end else begin
            st_nxt.held_key = pick;
            st_nxt.hold_count = '0;
            st_nxt.marks = 2'b00;
            res.beep = 1'b1;
            if (cfg.hold_limit_ticks == '0) begin
              res.key_event = classify(pick, {{CNT_W{1'b0}}, 1'b1}, cfg);
              st_nxt.phase = PH_WAIT;
            end else begin
              st_nxt.phase = PH_HOLD;
            end
          end
        end
        PH_HOLD: begin
          if (!dn[st.held_key]) begin
            res.key_event = classify(st.held_key, cnt_inc, cfg);
            st_nxt.phase = PH_IDLE;
          end else begin
            st_nxt.hold_count = cnt_inc[CNT_W-1:0];
            // second threshold takes precedence; each mark fires once per hold
            if (st.held_key == K_ESC) begin
              if (cnt_inc > {1'b0, cfg.esc_very_long_ticks}) begin
                if (!st.marks[1]) begin
                  st_nxt.marks[1] = 1'b1;
                  res.beep = 1'b1;
                end
              end else if (cnt_inc > {1'b0, cfg.long_ticks}) begin
                if (!st.marks[0]) begin
                  st_nxt.marks[0] = 1'b1;
                  res.beep = 1'b1;
                end
              end
            end else if (st.held_key == K_ENTER) begin
              if (cnt_inc > {1'b0, cfg.enter_mid_ticks}) begin
                if (!st.marks[1]) begin
                  st_nxt.marks[1] = 1'b1;
                  res.enter_stage = STG_6S;
                end
              end else if (cnt_inc > {1'b0, cfg.long_ticks}) begin
                if (!st.marks[0]) begin
                  st_nxt.marks[0] = 1'b1;
                  res.enter_stage = STG_3S;
                end
              end
            end
            if (cnt_inc >= lim_ext) begin
              res.key_event = classify(st.held_key, lim_ext + {{CNT_W{1'b0}}, 1'b1}, cfg);
              st_nxt.phase = PH_WAIT;
            end
          end
        end
        default: begin
          if (!any_dn) st_nxt.phase = PH_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
